// ===== rtl/grid_boundary_exit_path_count_defines.svh =====
// Assertion macros shared by the grid exit path counter checker.
`ifndef GRID_BOUNDARY_EXIT_PATH_COUNT_DEFINES_SVH
`define GRID_BOUNDARY_EXIT_PATH_COUNT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GBEPC_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gbepc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GBEPC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gbepc: next-cycle check failed");

`endif

// ===== rtl/gbepc_pkg.sv =====
// Package: types, constants and helper functions of the grid exit path counter.
package gbepc_pkg;

   localparam int DEF_MAX_ROWS  = 64;
   localparam int DEF_MAX_COLS  = 64;
   localparam int DEF_MAX_MOVES = 64;

   localparam int SIZE_W  = 7;
   localparam int START_W = 6;
   localparam int COUNT_W = 30;

   localparam logic [COUNT_W-1:0] PATH_MOD   = 30'd1000000007;
   localparam logic [31:0]        TWICE_MOD  = 32'd2000000014;

   typedef struct packed {
      logic [SIZE_W-1:0]  grid_rows;
      logic [SIZE_W-1:0]  grid_cols;
      logic [SIZE_W-1:0]  move_budget;
      logic [START_W-1:0] start_row;
      logic [START_W-1:0] start_col;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] path_count;
      logic               bad_start;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_REPLY
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_en;
      logic next_move;
   } cmd_type;

   typedef struct packed {
      logic bad_start;
      logic zero_moves;
      logic scan_last;
      logic last_move;
      logic pipe_empty;
   } sts_type;

   // Bits needed to index n entries, at least one.
   function automatic int idx_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

   // Sum of two residues, reduced once.
   function automatic logic [COUNT_W-1:0] mod_add(input logic [COUNT_W-1:0] a,
                                                   input logic [COUNT_W-1:0] b);
      logic [COUNT_W:0] s;
      logic [COUNT_W:0] d;
      s = {1'b0, a} + {1'b0, b};
      d = s - {1'b0, PATH_MOD};
      return (s >= {1'b0, PATH_MOD}) ? d[COUNT_W-1:0] : s[COUNT_W-1:0];
   endfunction

endpackage

// ===== rtl/grid_boundary_exit_path_count.sv =====
// Top level of the grid exit path counter: controller plus datapath.
//
// Counts, modulo 1000000007, the four-direction walks of at most move_budget
// moves that start on (start_row, start_col) of a grid_rows by grid_cols grid
// and leave it. Sizes above MAX_ROWS/MAX_COLS and budgets above MAX_MOVES are
// saturated. A request is taken when start is high and busy is low; busy then
// stays high until the single result has been shown. The result on rsp_data
// is flagged by rsp_valid for exactly one cycle and cannot be held off:
// capture it on that cycle. A start cell outside the grid gives path_count 0
// with bad_start set; a zero budget gives 0 with bad_start clear. Both of
// those go from ST_CHECK straight to ST_REPLY. Otherwise each move is one
// raster pass over (rows + 1) rows of MAX_COLS cells of the count grid at
// one cell per cycle, bound by the single read port of the count-grid
// memory, followed by a drain of the pipeline (read, window, sum and exit
// reduction stages); the result is shown after the drain of the last move,
// and the next request can be taken once busy is low again. No clearing
// pass is needed after reset: each move overwrites every in-use cell it
// later reads.
module grid_boundary_exit_path_count #(
   parameter int MAX_ROWS  = gbepc_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS  = gbepc_pkg::DEF_MAX_COLS,
   parameter int MAX_MOVES = gbepc_pkg::DEF_MAX_MOVES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  gbepc_pkg::req_type req_data,
   output logic               rsp_valid,
   output gbepc_pkg::rsp_type rsp_data
);

   // command and status between the sequencer and the datapath
   gbepc_pkg::cmd_type cmd;
   gbepc_pkg::sts_type sts;

   // Sequencer: load the request, scan once per move, drain, then reply.
   gbepc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // Datapath: ping-pong grids, neighbour window, exit accumulation.
   gbepc_dp #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .MAX_MOVES (MAX_MOVES)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== rtl/gbepc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gbepc_ram #(
   parameter int WIDTH = gbepc_pkg::COUNT_W,
   parameter int DEPTH = gbepc_pkg::DEF_MAX_ROWS * gbepc_pkg::DEF_MAX_COLS
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [gbepc_pkg::idx_width(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [gbepc_pkg::idx_width(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/gbepc_ctrl.sv =====
// Controller state machine: sequences load, per-move scans, drains and the reply.
module gbepc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  gbepc_pkg::sts_type sts,
   output gbepc_pkg::cmd_type cmd,
   output logic               busy,
   output logic               rsp_valid
);

   gbepc_pkg::state_type state_ff;
   gbepc_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gbepc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         gbepc_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = gbepc_pkg::ST_CHECK;
            end
         end
         gbepc_pkg::ST_CHECK: begin
            if (sts.bad_start || sts.zero_moves) begin
               state_in = gbepc_pkg::ST_REPLY;
            end else begin
               state_in = gbepc_pkg::ST_SCAN;
            end
         end
         gbepc_pkg::ST_SCAN: begin
            cmd.scan_en = 1'b1;
            if (sts.scan_last) begin
               state_in = gbepc_pkg::ST_DRAIN;
            end
         end
         gbepc_pkg::ST_DRAIN: begin
            // wait for the last writes of this move to land
            if (sts.pipe_empty) begin
               if (sts.last_move) begin
                  state_in = gbepc_pkg::ST_REPLY;
               end else begin
                  cmd.next_move = 1'b1;
                  state_in      = gbepc_pkg::ST_SCAN;
               end
            end
         end
         gbepc_pkg::ST_REPLY: begin
            rsp_valid = 1'b1;
            state_in  = gbepc_pkg::ST_IDLE;
         end
         default: begin
            state_in = gbepc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/gbepc_dp.sv =====
// Datapath: request registers, scan address generation, ping-pong count grids,
// neighbour window and exit total accumulation.
module gbepc_dp #(
   parameter int MAX_ROWS  = gbepc_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS  = gbepc_pkg::DEF_MAX_COLS,
   parameter int MAX_MOVES = gbepc_pkg::DEF_MAX_MOVES
) (
   input  logic               clock,
   input  logic               reset,
   input  gbepc_pkg::cmd_type cmd,
   output gbepc_pkg::sts_type sts,
   input  gbepc_pkg::req_type req_data,
   output gbepc_pkg::rsp_type rsp_data
);

   localparam int RCW   = gbepc_pkg::idx_width(MAX_ROWS + 1);
   localparam int CCW   = gbepc_pkg::idx_width(MAX_COLS + 1);
   localparam int CIW   = gbepc_pkg::idx_width(MAX_COLS);
   localparam int MCW   = gbepc_pkg::idx_width(MAX_MOVES + 1);
   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int AW    = gbepc_pkg::idx_width(DEPTH);
   localparam int SLEN  = 2 * MAX_COLS + 1;
   localparam int CW    = gbepc_pkg::COUNT_W;
   localparam int SW    = gbepc_pkg::START_W;

   // request registers
   logic [RCW-1:0] rows_ff,  rows_in;
   logic [CCW-1:0] cols_ff,  cols_in;
   logic [MCW-1:0] moves_ff, moves_in;
   logic [SW-1:0]  srow_ff,  srow_in;
   logic [SW-1:0]  scol_ff,  scol_in;
   logic           bad_ff,   bad_in;

   // scan and move counters
   logic [RCW-1:0] rd_row_ff, rd_row_in;
   logic [CIW-1:0] rd_col_ff, rd_col_in;
   logic [MCW-1:0] move_ff,   move_in;

   // read stage
   logic           s1_valid_ff, s1_valid_in;
   logic [RCW-1:0] s1_row_ff,   s1_row_in;
   logic [CIW-1:0] s1_col_ff,   s1_col_in;
   logic           s1_inuse_ff, s1_inuse_in;

   // window stage
   logic [CW-1:0]  line_ff [SLEN];
   logic [CW-1:0]  line_in [SLEN];
   logic           s2_valid_ff, s2_valid_in;
   logic [RCW-1:0] s2_row_ff,   s2_row_in;
   logic [CIW-1:0] s2_col_ff,   s2_col_in;

   // sum stage
   logic           a_valid_ff, a_valid_in;
   logic [AW-1:0]  a_addr_ff,  a_addr_in;
   logic [CW-1:0]  a_ud_ff,    a_ud_in;
   logic [CW-1:0]  a_lr_ff,    a_lr_in;
   logic [31:0]    a_kv_ff,    a_kv_in;

   // exit reduction stages
   logic           b_valid_ff, b_valid_in;
   logic [31:0]    b_kv_ff,    b_kv_in;
   logic           c_valid_ff, c_valid_in;
   logic [CW-1:0]  c_val_ff,   c_val_in;
   logic [CW-1:0]  exit_ff,    exit_in;

   logic [31:0]    rows_req, cols_req, moves_req;
   logic [31:0]    rows_sat, cols_sat, moves_sat;
   logic           bad_req;
   logic [AW-1:0]  rd_addr;
   logic           rd_inuse;
   logic [CW-1:0]  ram_a_rd, ram_b_rd;
   logic [CW-1:0]  src_val, x_val;
   logic           top_edge, bot_edge, left_edge, right_edge, right_mem;
   logic           emit;
   logic [CW-1:0]  up_v, down_v, left_v, right_v, center_v;
   logic [2:0]     exits;
   logic [CW-1:0]  wr_data;
   logic           wr_a, wr_b;

   // Saturate the request and decide the bad start case.
   always_comb begin
      rows_req  = 32'(req_data.grid_rows);
      cols_req  = 32'(req_data.grid_cols);
      moves_req = 32'(req_data.move_budget);
      rows_sat  = (rows_req  > 32'(MAX_ROWS))  ? 32'(MAX_ROWS)  : rows_req;
      cols_sat  = (cols_req  > 32'(MAX_COLS))  ? 32'(MAX_COLS)  : cols_req;
      moves_sat = (moves_req > 32'(MAX_MOVES)) ? 32'(MAX_MOVES) : moves_req;
      bad_req   = (32'(req_data.start_row) >= rows_sat) ||
                  (32'(req_data.start_col) >= cols_sat);
   end

   always_comb begin
      rows_in  = rows_ff;
      cols_in  = cols_ff;
      moves_in = moves_ff;
      srow_in  = srow_ff;
      scol_in  = scol_ff;
      bad_in   = bad_ff;
      if (cmd.load) begin
         rows_in  = RCW'(rows_sat);
         cols_in  = CCW'(cols_sat);
         moves_in = MCW'(moves_sat);
         srow_in  = req_data.start_row;
         scol_in  = req_data.start_col;
         bad_in   = bad_req;
      end
   end

   // Raster scan over rows 0..rows with a fixed row stride of MAX_COLS.
   always_comb begin
      rd_row_in = rd_row_ff;
      rd_col_in = rd_col_ff;
      move_in   = move_ff;
      if (cmd.load) begin
         rd_row_in = '0;
         rd_col_in = '0;
         move_in   = '0;
      end else if (cmd.next_move) begin
         rd_row_in = '0;
         rd_col_in = '0;
         move_in   = move_ff + 1'b1;
      end else if (cmd.scan_en) begin
         if (32'(rd_col_ff) == 32'(MAX_COLS - 1)) begin
            rd_col_in = '0;
            rd_row_in = rd_row_ff + 1'b1;
         end else begin
            rd_col_in = rd_col_ff + 1'b1;
         end
      end
   end

   assign rd_addr  = AW'(32'(rd_row_ff) * 32'(MAX_COLS) + 32'(rd_col_ff));
   assign rd_inuse = (32'(rd_row_ff) < 32'(rows_ff)) && (32'(rd_col_ff) < 32'(cols_ff));

   always_comb begin
      s1_valid_in = cmd.scan_en;
      s1_row_in   = rd_row_ff;
      s1_col_in   = rd_col_ff;
      s1_inuse_in = rd_inuse;
   end

   // Move 0 reads the seed; later moves read the grid written by the move before.
   always_comb begin
      if (move_ff == '0) begin
         src_val = ((32'(s1_row_ff) == 32'(srow_ff)) && (32'(s1_col_ff) == 32'(scol_ff)))
                   ? CW'(1) : '0;
      end else if (move_ff[0]) begin
         src_val = ram_a_rd;
      end else begin
         src_val = ram_b_rd;
      end
      x_val = s1_inuse_ff ? src_val : '0;
   end

   always_comb begin
      line_in     = line_ff;
      s2_valid_in = s1_valid_ff;
      s2_row_in   = s2_row_ff;
      s2_col_in   = s2_col_ff;
      if (s1_valid_ff) begin
         line_in[0] = x_val;
         for (int k = 1; k < SLEN; k++) begin
            line_in[k] = line_ff[k-1];
         end
         s2_row_in = s1_row_ff;
         s2_col_in = s1_col_ff;
      end
   end

   // Window centre is one row behind the newest sample.
   always_comb begin
      top_edge   = (32'(s2_row_ff) == 32'd1);
      bot_edge   = (32'(s2_row_ff) == 32'(rows_ff));
      left_edge  = (s2_col_ff == '0);
      right_edge = ((32'(s2_col_ff) + 32'd1) == 32'(cols_ff));
      right_mem  = (32'(s2_col_ff) == 32'(MAX_COLS - 1));
      emit       = s2_valid_ff && (s2_row_ff != '0) && (32'(s2_col_ff) < 32'(cols_ff));
      center_v   = line_ff[MAX_COLS];
      down_v     = line_ff[0];
      up_v       = top_edge  ? '0 : line_ff[2*MAX_COLS];
      left_v     = left_edge ? '0 : line_ff[MAX_COLS+1];
      right_v    = right_mem ? '0 : line_ff[MAX_COLS-1];
      exits      = {2'b00, top_edge} + {2'b00, bot_edge} +
                   {2'b00, left_edge} + {2'b00, right_edge};
   end

   always_comb begin
      a_valid_in = emit;
      a_addr_in  = AW'(32'(s2_row_ff) * 32'(MAX_COLS) + 32'(s2_col_ff) - 32'(MAX_COLS));
      a_ud_in    = gbepc_pkg::mod_add(up_v, down_v);
      a_lr_in    = gbepc_pkg::mod_add(left_v, right_v);
      case (exits)
         3'd0:    a_kv_in = '0;
         3'd1:    a_kv_in = {2'b00, center_v};
         3'd2:    a_kv_in = {1'b0, center_v, 1'b0};
         3'd3:    a_kv_in = {2'b00, center_v} + {1'b0, center_v, 1'b0};
         3'd4:    a_kv_in = {center_v, 2'b00};
         default: a_kv_in = '0;
      endcase
   end

   // Write the new count into the grid not being read this move.
   assign wr_data = gbepc_pkg::mod_add(a_ud_ff, a_lr_ff);
   assign wr_a    = a_valid_ff && !move_ff[0];
   assign wr_b    = a_valid_ff &&  move_ff[0];

   always_comb begin
      b_valid_in = a_valid_ff;
      b_kv_in    = (a_kv_ff >= gbepc_pkg::TWICE_MOD) ? a_kv_ff - gbepc_pkg::TWICE_MOD
                                                      : a_kv_ff;
      c_valid_in = b_valid_ff;
      c_val_in   = (b_kv_ff >= 32'(gbepc_pkg::PATH_MOD))
                   ? CW'(b_kv_ff - 32'(gbepc_pkg::PATH_MOD)) : CW'(b_kv_ff);
      if (cmd.load) begin
         exit_in = '0;
      end else if (c_valid_ff) begin
         exit_in = gbepc_pkg::mod_add(exit_ff, c_val_ff);
      end else begin
         exit_in = exit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_row_ff   <= '0;
         rd_col_ff   <= '0;
         move_ff     <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         a_valid_ff  <= 1'b0;
         b_valid_ff  <= 1'b0;
         c_valid_ff  <= 1'b0;
         exit_ff     <= '0;
      end else begin
         rd_row_ff   <= rd_row_in;
         rd_col_ff   <= rd_col_in;
         move_ff     <= move_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         a_valid_ff  <= a_valid_in;
         b_valid_ff  <= b_valid_in;
         c_valid_ff  <= c_valid_in;
         exit_ff     <= exit_in;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff     <= rows_in;
      cols_ff     <= cols_in;
      moves_ff    <= moves_in;
      srow_ff     <= srow_in;
      scol_ff     <= scol_in;
      bad_ff      <= bad_in;
      s1_row_ff   <= s1_row_in;
      s1_col_ff   <= s1_col_in;
      s1_inuse_ff <= s1_inuse_in;
      line_ff     <= line_in;
      s2_row_ff   <= s2_row_in;
      s2_col_ff   <= s2_col_in;
      a_addr_ff   <= a_addr_in;
      a_ud_ff     <= a_ud_in;
      a_lr_ff     <= a_lr_in;
      a_kv_ff     <= a_kv_in;
      b_kv_ff     <= b_kv_in;
      c_val_ff    <= c_val_in;
   end

   gbepc_ram #(
      .WIDTH (CW),
      .DEPTH (DEPTH)
   ) u_grid_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (a_addr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_a_rd)
   );

   gbepc_ram #(
      .WIDTH (CW),
      .DEPTH (DEPTH)
   ) u_grid_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (a_addr_ff),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (ram_b_rd)
   );

   always_comb begin
      sts.bad_start  = bad_ff;
      sts.zero_moves = (moves_ff == '0);
      sts.scan_last  = (32'(rd_row_ff) == 32'(rows_ff)) &&
                       (32'(rd_col_ff) == 32'(MAX_COLS - 1));
      sts.last_move  = ((32'(move_ff) + 32'd1) == 32'(moves_ff));
      sts.pipe_empty = !(s1_valid_ff || s2_valid_ff || a_valid_ff ||
                         b_valid_ff || c_valid_ff);
   end

   assign rsp_data.path_count = exit_ff;
   assign rsp_data.bad_start  = bad_ff;

endmodule

// ===== rtl/gbepc_checker.sv =====
// Port-level checker for the grid exit path counter, bound to the top level.
`include "grid_boundary_exit_path_count_defines.svh"

module gbepc_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input gbepc_pkg::rsp_type rsp_data
);

   // an accepted request is followed by busy high
   `GBEPC_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
   // the reply lasts one cycle and frees the block
   `GBEPC_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid && !busy)
   `GBEPC_ASSERT_SAME(a_strobe_busy, rsp_valid, busy)
   `GBEPC_ASSERT_SAME(a_bad_zero, rsp_valid && rsp_data.bad_start, rsp_data.path_count == '0)
   `GBEPC_ASSERT_SAME(a_count_range, rsp_valid, rsp_data.path_count < gbepc_pkg::PATH_MOD)

endmodule

bind grid_boundary_exit_path_count gbepc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
